@@ hdl/kds_pkg.sv @@
// ----------------------------------------------------------------------------
// kds_pkg
// Shared constants and types for the keypad debounce scanner.
// ----------------------------------------------------------------------------
package kds_pkg;

   // number of keys in one scan
   localparam int NUM_KEYS = 12;

   // key number 1..NUM_KEYS, 0 means no key
   localparam int KEY_CODE_W = $clog2(NUM_KEYS + 1);

   // stability counter and threshold width
   localparam int COUNT_W = 8;

   // threshold after reset, and the largest threshold the counter can serve
   localparam logic [COUNT_W-1:0] DEFAULT_STABLE_SCANS = COUNT_W'(5);
   localparam logic [COUNT_W-1:0] MAX_THRESHOLD        = COUNT_W'(254);

   typedef logic [NUM_KEYS-1:0]   key_vec_type;
   typedef logic [KEY_CODE_W-1:0] key_code_type;
   typedef logic [COUNT_W-1:0]    count_type;

endpackage

@@ hdl/kds_req_if.sv @@
// ----------------------------------------------------------------------------
// kds_req_if
// Scan channel: one beat carries the levels of all keys for one scan.
// ----------------------------------------------------------------------------
interface kds_req_if;

   logic                 valid;
   logic                 ready;
   kds_pkg::key_vec_type key_levels;

   modport source (output valid, output key_levels, input ready);
   modport sink   (input valid, input key_levels, output ready);

endinterface

@@ hdl/kds_rsp_if.sv @@
// ----------------------------------------------------------------------------
// kds_rsp_if
// Result channel: one beat per scan with the reported key number.
// ----------------------------------------------------------------------------
interface kds_rsp_if;

   logic                  valid;
   logic                  ready;
   kds_pkg::key_code_type key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);

endinterface

@@ hdl/keypad_debounce_scanner.sv @@
// ----------------------------------------------------------------------------
// keypad_debounce_scanner
// Per-key counter debounce over one scan per beat, reporting the highest
// newly stable pressed key.
//
//   port       direction  beat contents
//   req_beat   in         key_levels[11:0], bit i = key i+1 pressed
//   rsp_beat   out        key_code[3:0], 1..12 or 0 for no key
//   csr_*      in         stable_scans[7:0] threshold, write only
//
// One scan per cycle: all key lanes update in the cycle a req beat is taken,
// the merge stage registers the key code, which appears in the next cycle.
// Throughput is one beat per cycle, set by the single output register;
// req_beat.ready drops only while a result waits and rsp_beat.ready is low.
// Synchronous reset releases all keys, clears the counters, sets threshold 5.
// ----------------------------------------------------------------------------
module keypad_debounce_scanner (
   input  logic               clock,
   input  logic               reset,
   kds_req_if.sink            req_beat,
   kds_rsp_if.source          rsp_beat,
   input  logic               csr_wr_en,
   input  kds_pkg::count_type csr_wr_data
);

   kds_pkg::count_type   stable_scans_ff;
   kds_pkg::count_type   limit;
   kds_pkg::key_vec_type hits;
   logic                 space_ok;
   logic                 advance;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_scans_ff <= kds_pkg::DEFAULT_STABLE_SCANS;
      end else if (csr_wr_en) begin
         stable_scans_ff <= csr_wr_data;
      end
   end

   // keep the counter within 8 bits
   assign limit = (stable_scans_ff > kds_pkg::MAX_THRESHOLD) ? kds_pkg::MAX_THRESHOLD
                                                             : stable_scans_ff;

   assign req_beat.ready = space_ok;
   assign advance        = req_beat.valid && space_ok;

   // one lane per key
   for (genvar k = 0; k < kds_pkg::NUM_KEYS; k++) begin : g_lane
      kds_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .level_now (req_beat.key_levels[k]),
         .limit     (limit),
         .hit       (hits[k])
      );
   end

   // merge and result register
   kds_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .hits     (hits),
      .space_ok (space_ok),
      .rsp_beat (rsp_beat)
   );

endmodule

@@ hdl/kds_lane.sv @@
// ----------------------------------------------------------------------------
// kds_lane
// Debounce core for one key: last level, stability counter and press flag.
// ----------------------------------------------------------------------------
module kds_lane (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                level_now,
   input  kds_pkg::count_type  limit,
   output logic                hit
);

   logic               level_ff;
   logic               level_in;
   kds_pkg::count_type count_ff;
   kds_pkg::count_type count_in;
   kds_pkg::count_type count_base;
   kds_pkg::count_type count_step;

   // level change restarts the count
   assign count_base = (level_now != level_ff) ? '0 : count_ff;

   // count toward the threshold
   assign count_step = (count_base < limit) ? count_base + kds_pkg::COUNT_W'(1) : count_base;

   // pressed and just stable: report once and move past the threshold
   assign hit      = level_now && (count_step == limit);
   assign count_in = hit ? count_step + kds_pkg::COUNT_W'(1) : count_step;
   assign level_in = level_now;

   // key state
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ hdl/kds_merge.sv @@
// ----------------------------------------------------------------------------
// kds_merge
// Picks the highest reporting key and holds the result beat for the sink.
// ----------------------------------------------------------------------------
module kds_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  kds_pkg::key_vec_type hits,
   output logic                 space_ok,
   kds_rsp_if.source            rsp_beat
);

   logic                  valid_ff;
   logic                  valid_in;
   kds_pkg::key_code_type key_code_ff;
   kds_pkg::key_code_type key_code_in;

   // highest key number wins
   always_comb begin
      key_code_in = '0;
      for (int i = 0; i < kds_pkg::NUM_KEYS; i++) begin
         if (hits[i]) begin
            key_code_in = kds_pkg::KEY_CODE_W'(i + 1);
         end
      end
   end

   // output register is free when empty or being drained
   assign space_ok = !valid_ff || rsp_beat.ready;
   assign valid_in = advance || (valid_ff && !rsp_beat.ready);

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         key_code_ff <= key_code_in;
      end
   end

   assign rsp_beat.valid    = valid_ff;
   assign rsp_beat.key_code = key_code_ff;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad debounce scanner. A queue-fed driver
// sends scans with random gaps. A tracking model of the per-key levels and
// stability counters predicts each key code. A monitor with random stalls
// checks every result beat in order. The threshold is stepped through
// several values, including zero and both top values.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_WAIT    = 11;
   localparam int SHOWN_FAILS = 10;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   kds_pkg::count_type csr_wr_data;

   kds_req_if req_ch ();
   kds_rsp_if rsp_ch ();

   keypad_debounce_scanner dut (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_ch),
      .rsp_beat    (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // scans waiting to be sent, key codes waiting to arrive
   kds_pkg::key_vec_type  scan_q[$];
   kds_pkg::key_code_type code_q[$];

   // tracking model of the debounce state
   logic               seen_level [kds_pkg::NUM_KEYS];
   kds_pkg::count_type settle_count [kds_pkg::NUM_KEYS];
   kds_pkg::count_type active_limit;

   int fail_count       = 0;
   int scans_sent       = 0;
   int codes_checked    = 0;
   int keys_reported    = 0;
   int thresholds_tried = 0;
   int cycle_count      = 0;

   int  gap_left   = 0;
   int  stall_left = 0;
   bit  send_calm  = 1'b0;
   bit  take_calm  = 1'b0;

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // update the model with one scan, return the code it reports
   function automatic kds_pkg::key_code_type debounce_scan(input kds_pkg::key_vec_type levels);
      kds_pkg::key_code_type code;
      code = '0;
      for (int k = 0; k < kds_pkg::NUM_KEYS; k++) begin
         if (levels[k] != seen_level[k]) begin
            settle_count[k] = '0;
            seen_level[k]   = levels[k];
         end
         if (settle_count[k] < active_limit)
            settle_count[k] = settle_count[k] + 1'b1;
         if (levels[k] && settle_count[k] == active_limit) begin
            settle_count[k] = settle_count[k] + 1'b1;
            code            = kds_pkg::key_code_type'(k + 1);
         end
      end
      return code;
   endfunction

   // idle cycles for one item, zero throughout a calm stretch
   function automatic int draw_wait(input bit calm);
      return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
   endfunction

   // scan driver
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.key_levels <= '0;
      end else begin
         next_valid = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            code_q.push_back(debounce_scan(req_ch.key_levels));
            scans_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (scan_q.size() != 0) begin
               req_ch.key_levels <= scan_q.pop_front();
               next_valid = 1'b1;
               if ($urandom_range(0, 39) == 0)
                  send_calm = !send_calm;
               gap_left = draw_wait(send_calm);
            end
         end
         req_ch.valid <= next_valid;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      logic                  next_ready;
      kds_pkg::key_code_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         next_ready = rsp_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            next_ready = 1'b0;
            if (code_q.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOWN_FAILS)
                  $display("unexpected result beat: key_code %0d", rsp_ch.key_code);
            end else begin
               want = code_q.pop_front();
               codes_checked++;
               if (want != 0)
                  keys_reported++;
               if (rsp_ch.key_code !== want) begin
                  fail_count++;
                  if (fail_count <= SHOWN_FAILS)
                     $display("key_code mismatch at result %0d: expected %0d, got %0d",
                              codes_checked, want, rsp_ch.key_code);
               end
            end
         end
         if (!next_ready) begin
            if (stall_left > 0) begin
               stall_left--;
            end else begin
               next_ready = 1'b1;
               if ($urandom_range(0, 39) == 0)
                  take_calm = !take_calm;
               stall_left = draw_wait(take_calm);
            end
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // queue the same scan several times
   task automatic hold_scan(input kds_pkg::key_vec_type levels, input int count);
      repeat (count) scan_q.push_back(levels);
   endtask

   // wait until every scan is sent and every code has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (scan_q.size() != 0 || req_ch.valid || code_q.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   // new threshold, only while the block is idle
   task automatic write_threshold(input kds_pkg::count_type value);
      wait_drained();
      @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value;
      active_limit = (value > kds_pkg::MAX_THRESHOLD) ? kds_pkg::MAX_THRESHOLD : value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      thresholds_tried++;
   endtask

   // mostly presses held past the threshold after some bounce,
   // the rest short presses and noise
   task automatic add_episodes(input int budget);
      int                   added;
      int                   hold;
      int                   pick;
      kds_pkg::key_vec_type pat;
      kds_pkg::key_vec_type flip;
      added = 0;
      while (added < budget) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)
            pat = kds_pkg::key_vec_type'(1 << $urandom_range(0, kds_pkg::NUM_KEYS - 1));
         else if (pick == 3)
            pat = '1;
         else if (pick == 4)
            pat = '0;
         else
            pat = kds_pkg::key_vec_type'($urandom);
         if ($urandom_range(0, 9) < 8) begin
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 1)) begin
                  flip = kds_pkg::key_vec_type'(1 << $urandom_range(0, kds_pkg::NUM_KEYS - 1));
                  scan_q.push_back(pat ^ flip);
               end else begin
                  scan_q.push_back(kds_pkg::key_vec_type'($urandom));
               end
               added++;
            end
            hold = int'(active_limit) + $urandom_range(0, 3);
            if (hold == 0)
               hold = 1;
            hold_scan(pat, hold);
            added += hold;
         end else begin
            hold = $urandom_range(1, int'(active_limit) / 2 + 1);
            hold_scan(pat, hold);
            added += hold;
            repeat ($urandom_range(1, 4)) begin
               scan_q.push_back(kds_pkg::key_vec_type'($urandom));
               added++;
            end
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      kds_pkg::count_type phase_limit [6];
      int                 phase_budget [6];
      phase_limit  = '{8'd0, 8'd1, 8'd255, 8'd254, 8'd2,
                       kds_pkg::count_type'($urandom_range(3, 12))};
      phase_budget = '{250, 250, 200, 200, 200, 180};

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_ch.valid      = 1'b0;
      req_ch.key_levels = '0;
      rsp_ch.ready      = 1'b0;
      active_limit      = kds_pkg::DEFAULT_STABLE_SCANS;
      for (int k = 0; k < kds_pkg::NUM_KEYS; k++) begin
         seen_level[k]   = 1'b0;
         settle_count[k] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed scans at the reset threshold: idle, all keys at once,
      // lowest key, then a release of it while the highest key settles
      hold_scan('0, 2);
      hold_scan('1, 6);
      hold_scan('0, 1);
      hold_scan(kds_pkg::key_vec_type'(1), 6);
      hold_scan(kds_pkg::key_vec_type'(1) << (kds_pkg::NUM_KEYS - 1), 6);
      add_episodes(250);

      for (int p = 0; p < 6; p++) begin
         write_threshold(phase_limit[p]);
         add_episodes(phase_budget[p]);
      end

      // back to the reset value to end on a typical setting
      write_threshold(kds_pkg::DEFAULT_STABLE_SCANS);
      add_episodes(100);

      wait_drained();
      repeat (8) @(posedge clock);
      if (code_q.size() != 0) begin
         fail_count += code_q.size();
         $display("%0d expected key codes never arrived", code_q.size());
      end

      $display("sent %0d scans over %0d threshold settings plus the reset value",
               scans_sent, thresholds_tried);
      $display("checked %0d key codes, %0d of them reporting a key",
               codes_checked, keys_reported);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/kds_pkg.sv
hdl/kds_req_if.sv
hdl/kds_rsp_if.sv
hdl/kds_lane.sv
hdl/kds_merge.sv
hdl/keypad_debounce_scanner.sv
tb/testbench.sv
